>>> rtl/cdo_pkg.sv
`timescale 1ns / 1ps
package cdo_pkg;

    localparam int HIST_BINS  = 256;
    localparam int MAG_BITS   = 24;
    localparam int ANGLE_BITS = 16;
    localparam int IDX_BITS   = $clog2(HIST_BINS);
    localparam int SUM_BITS   = 34;
    localparam int TERM_BITS  = 29;
    localparam int XW         = 38;
    localparam int ZW         = 33;
    localparam int STAGES     = 16;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam logic [15:0] INV_GAIN = 16'd39797;
    localparam logic [15:0] PHASE_STEP_RESET = 16'd16384;
    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

    typedef struct packed {
        logic [MAG_BITS-1:0]   pmag;
        logic [ANGLE_BITS-1:0] delta;
        logic [MAG_BITS-1:0]   amag;
        logic                  do_term;
        logic                  last;
        logic                  had_hist;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOAD,
        B_ROT,
        B_DIFF,
        B_VEC,
        B_SCALE,
        B_ACC,
        B_EMIT
    } back_state_t;

    function automatic logic signed [ZW-1:0] atan_lut(input logic [3:0] k);
        logic signed [ZW-1:0] v;
        case (k)
            4'd0:    v = 33'sd536870912;
            4'd1:    v = 33'sd316933406;
            4'd2:    v = 33'sd167458907;
            4'd3:    v = 33'sd85004756;
            4'd4:    v = 33'sd42667331;
            4'd5:    v = 33'sd21354465;
            4'd6:    v = 33'sd10679838;
            4'd7:    v = 33'sd5340245;
            4'd8:    v = 33'sd2670163;
            4'd9:    v = 33'sd1335087;
            4'd10:   v = 33'sd667544;
            4'd11:   v = 33'sd333772;
            4'd12:   v = 33'sd166886;
            4'd13:   v = 33'sd83443;
            4'd14:   v = 33'sd41721;
            default: v = 33'sd20860;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/complex_domain_onset.sv
`timescale 1ns / 1ps
// Complex-domain onset detector: one spectrum bin per transfer, frame ends on
// tlast, one onset value per frame. A front stage reads and rewrites the bin
// history memory and forms the phase deviation; a 4-entry queue feeds a back
// stage whose iterative rotate/vector CORDIC unit handles one queued bin at a
// time: it sums a term for every bin but bin 0 once a frame has history, and
// emits the frame result after the last bin. A new bin is not taken from the
// queue until the CORDIC iterations for the one before it are done.
module complex_domain_onset (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // bin_magnitude[23:0], bin_phase[39:24]
    input  logic        s_axis_tlast,   // last_bin
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // onset_value[33:0], zero fill
    output logic [0:0]  m_axis_tuser,   // had_history[0]
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import cdo_pkg::*;

    logic [15:0] phase_step_reg;
    logic        push;
    logic        pop;
    job_t        push_data;
    job_t        pop_data;
    q_stat_t     q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= PHASE_STEP_RESET;
        end
        else if (cfg_we)
        begin
            phase_step_reg <= cfg_wdata;
        end
    end

    cdo_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .phase_step    (phase_step_reg),
        .q_stat        (q_stat),
        .job_valid     (push),
        .job           (push_data)
    );

    cdo_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    cdo_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .q_data        (pop_data),
        .q_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("queue underflow");

    a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 40'd0))
        else $error("onset without history is not zero");

    a_ready_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !s_axis_tready)
        else $error("transfer taken while a bin is pending");

endmodule

>>> rtl/cdo_front.sv
`timescale 1ns / 1ps
module cdo_front (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  logic [39:0]                               s_axis_tdata,
    input  logic                                      s_axis_tlast,
    input  logic [15:0]                               phase_step,
    input  cdo_pkg::q_stat_t                          q_stat,
    output logic                                      job_valid,
    output cdo_pkg::job_t                             job
);
    import cdo_pkg::*;

    logic [MAG_BITS+ANGLE_BITS-1:0] hist_mem [HIST_BINS];
    logic [MAG_BITS+ANGLE_BITS-1:0] rd_reg;
    logic                           pend_reg;
    logic [IDX_BITS-1:0]            cnt_reg;
    logic                           hv_reg;
    logic [MAG_BITS-1:0]            amag_reg;
    logic [ANGLE_BITS-1:0]          ph_reg;
    logic [IDX_BITS-1:0]            idx_reg;
    logic                           last_reg;
    logic                           term_reg;
    logic                           hvcap_reg;
    logic                           accept;
    logic [IDX_BITS+15:0]           advance;
    logic [ANGLE_BITS-1:0]          expect_ph;

    assign s_axis_tready = !pend_reg && !q_stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hist_mem[cnt_reg] <= {s_axis_tdata[MAG_BITS+ANGLE_BITS-1:MAG_BITS],
                                  s_axis_tdata[MAG_BITS-1:0]};
            rd_reg   <= hist_mem[cnt_reg];
            amag_reg <= s_axis_tdata[MAG_BITS-1:0];
            ph_reg   <= s_axis_tdata[MAG_BITS+ANGLE_BITS-1:MAG_BITS];
            idx_reg  <= cnt_reg;
            last_reg <= s_axis_tlast;
            term_reg <= hv_reg && (cnt_reg != '0);
            hvcap_reg <= hv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            cnt_reg  <= '0;
            hv_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pend_reg <= 1'b1;
                if (s_axis_tlast)
                begin
                    cnt_reg <= '0;
                    hv_reg  <= 1'b1;
                end
                else if (cnt_reg == IDX_BITS'(HIST_BINS - 1))
                begin
                    cnt_reg <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            else
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    assign advance   = idx_reg * phase_step;
    assign expect_ph = rd_reg[MAG_BITS+ANGLE_BITS-1:MAG_BITS] + advance[ANGLE_BITS-1:0];

    assign job_valid    = pend_reg;
    assign job.pmag     = rd_reg[MAG_BITS-1:0];
    assign job.delta    = expect_ph - ph_reg;
    assign job.amag     = amag_reg;
    assign job.do_term  = term_reg;
    assign job.last     = last_reg;
    assign job.had_hist = hvcap_reg;

endmodule

>>> rtl/cdo_fifo.sv
`timescale 1ns / 1ps
module cdo_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cdo_pkg::job_t    push_data,
    input  logic             pop,
    output cdo_pkg::job_t    pop_data,
    output cdo_pkg::q_stat_t stat
);
    import cdo_pkg::*;

    job_t                  slot_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg;
    logic [Q_PTR_BITS:0]   count_reg;

    assign stat.full  = (count_reg == (Q_PTR_BITS+1)'(Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/cdo_back.sv
`timescale 1ns / 1ps
module cdo_back (
    input  logic             clk,
    input  logic             rst_n,
    input  cdo_pkg::q_stat_t q_stat,
    input  cdo_pkg::job_t    q_data,
    output logic             q_pop,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [39:0]      m_axis_tdata,
    output logic [0:0]       m_axis_tuser
);
    import cdo_pkg::*;

    back_state_t                state_reg, state_next;
    job_t                       job_reg, job_next;
    logic [3:0]                 k_reg, k_next;
    logic signed [XW-1:0]       x_reg, x_next;
    logic signed [XW-1:0]       y_reg, y_next;
    logic signed [ZW-1:0]       z_reg, z_next;
    logic [TERM_BITS-1:0]       term_reg, term_next;
    logic [SUM_BITS-1:0]        sum_reg, sum_next;
    logic                       ov_reg, ov_next;
    logic [SUM_BITS-1:0]        od_reg, od_next;
    logic                       ou_reg, ou_next;

    logic [MAG_BITS+15:0]       pm_prod;
    logic [MAG_BITS+15:0]       pm_round;
    logic signed [XW-1:0]       x0;
    logic signed [ZW-1:0]       z0;
    logic signed [XW-1:0]       xs;
    logic signed [XW-1:0]       ys;
    logic signed [XW-1:0]       dx;
    logic [XW-2:0]              m_mag;
    logic [XW+14:0]             sc_prod;
    logic [SUM_BITS:0]          acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            sum_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        k_reg    <= k_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        term_reg <= term_next;
        od_reg   <= od_next;
        ou_reg   <= ou_next;
    end

    assign pm_prod  = job_reg.pmag * INV_GAIN;
    assign pm_round = pm_prod + (MAG_BITS+16)'(128);
    assign x0       = XW'(pm_round[MAG_BITS+15:8]);
    assign z0       = ZW'(signed'({job_reg.delta, {(32-ANGLE_BITS){1'b0}}}));
    assign xs       = x_reg >>> k_reg;
    assign ys       = y_reg >>> k_reg;
    assign dx       = XW'({job_reg.amag, 8'd0}) - x_reg;
    assign m_mag    = x_reg[XW-1] ? '0 : x_reg[XW-2:0];
    assign sc_prod  = m_mag * INV_GAIN + (XW+15)'(24'h800000);
    assign acc      = {1'b0, sum_reg} + (SUM_BITS+1)'(term_reg);

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        k_next     = k_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        term_next  = term_reg;
        sum_next   = sum_reg;
        ov_next    = ov_reg && !m_axis_tready;
        od_next    = od_reg;
        ou_next    = ou_reg;
        q_pop      = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop    = 1'b1;
                    job_next = q_data;
                    if (q_data.do_term)
                    begin
                        state_next = B_LOAD;
                    end
                    else if (q_data.last)
                    begin
                        state_next = B_EMIT;
                    end
                end
            end
            B_LOAD:
            begin
                y_next = '0;
                k_next = '0;
                if (z0 > ZW'(33'sd1073741824))
                begin
                    z_next = z0 - ZW'(33'sd2147483648);
                    x_next = -x0;
                end
                else if (z0 < -ZW'(33'sd1073741824))
                begin
                    z_next = z0 + ZW'(33'sd2147483648);
                    x_next = -x0;
                end
                else
                begin
                    z_next = z0;
                    x_next = x0;
                end
                state_next = B_ROT;
            end
            B_ROT:
            begin
                if (!z_reg[ZW-1])
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_lut(k_reg);
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_lut(k_reg);
                end
                k_next = k_reg + 1'b1;
                if (k_reg == 4'(STAGES - 1))
                begin
                    state_next = B_DIFF;
                end
            end
            B_DIFF:
            begin
                if (dx[XW-1])
                begin
                    x_next = -dx;
                    y_next = y_reg;
                end
                else
                begin
                    x_next = dx;
                    y_next = -y_reg;
                end
                k_next     = '0;
                state_next = B_VEC;
            end
            B_VEC:
            begin
                if (!y_reg[XW-1])
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                end
                k_next = k_reg + 1'b1;
                if (k_reg == 4'(STAGES - 1))
                begin
                    state_next = B_SCALE;
                end
            end
            B_SCALE:
            begin
                term_next  = sc_prod[XW+14:24];
                state_next = B_ACC;
            end
            B_ACC:
            begin
                sum_next   = (acc > {1'b0, SUM_MAX}) ? SUM_MAX : acc[SUM_BITS-1:0];
                state_next = job_reg.last ? B_EMIT : B_IDLE;
            end
            B_EMIT:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next    = 1'b1;
                    od_next    = job_reg.had_hist ? sum_reg : '0;
                    ou_next    = job_reg.had_hist;
                    sum_next   = '0;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {{(40-SUM_BITS){1'b0}}, od_reg};
    assign m_axis_tuser  = ou_reg;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import cdo_pkg::*;

    typedef struct {
        logic [23:0] mag;
        logic [15:0] ph;
        logic        last;
    } bin_t;

    typedef struct {
        logic [33:0] onset;
        logic        had;
    } onset_t;

    localparam int IDLE_WAIT = 200;
    localparam int STALL_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    complex_domain_onset dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    bin_t   pending_bins[$];
    onset_t expected_onsets[$];
    int     mismatches = 0;

    logic [23:0] hist_mag[HIST_BINS];
    logic [15:0] hist_ph[HIST_BINS];
    int          bin_idx = 0;
    longint      frame_total = 0;
    bit          hist_valid = 0;
    logic [15:0] step_model = PHASE_STEP_RESET;

    function automatic longint arc(int k);
        longint t[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                          21354465, 10679838, 5340245, 2670163, 1335087,
                          667544, 333772, 166886, 83443, 41721, 20860};
        return t[k];
    endfunction

    function automatic longint phasor_distance(logic [23:0] pmag, logic [15:0] pph,
                                               logic [23:0] amag, logic [15:0] aph,
                                               int idx, logic [15:0] step);
        logic [15:0] pred_ph;
        logic [15:0] d;
        logic [31:0] z32;
        longint      x, y, z, xs, ys;
        pred_ph = pph + 16'(idx * step);
        d = pred_ph - aph;
        z32 = {d, 16'h0};
        z = longint'(signed'(z32));
        x = (longint'(pmag) * 39797 + 128) >>> 8;
        y = 0;
        if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648;
            x = -x;
        end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648;
            x = -x;
        end
        for (int k = 0; k < 16; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (z >= 0) begin
                x -= ys; y += xs; z -= arc(k);
            end else begin
                x += ys; y -= xs; z += arc(k);
            end
        end
        x = longint'(amag) * 256 - x;
        y = -y;
        if (x < 0) begin
            x = -x;
            y = -y;
        end
        for (int k = 0; k < 16; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y >= 0) begin
                x += ys; y -= xs;
            end else begin
                x -= ys; y += xs;
            end
        end
        if (x < 0)
            x = 0;
        return (x * 39797 + 64'sd8388608) >>> 24;
    endfunction

    function automatic void predict_bin(bin_t b);
        onset_t r;
        longint lim;
        lim = (64'sd1 << 34) - 1;
        if (hist_valid && bin_idx != 0) begin
            frame_total += phasor_distance(hist_mag[bin_idx], hist_ph[bin_idx],
                                           b.mag, b.ph, bin_idx, step_model);
            if (frame_total > lim)
                frame_total = lim;
        end
        hist_mag[bin_idx] = b.mag;
        hist_ph[bin_idx] = b.ph;
        if (b.last) begin
            r.onset = hist_valid ? 34'(frame_total) : 34'd0;
            r.had = hist_valid;
            expected_onsets.push_back(r);
            hist_valid = 1;
            frame_total = 0;
            bin_idx = 0;
        end else begin
            bin_idx = (bin_idx + 1 >= HIST_BINS) ? 0 : bin_idx + 1;
        end
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // driver: bursts with gaps
    logic in_fire;
    int   burst_left = 0;
    int   gap_left = 0;

    always @(posedge clk)
        in_fire <= s_axis_tvalid && s_axis_tready;

    always @(negedge clk)
    begin
        bin_t b;
        if (rst_n && (!s_axis_tvalid || in_fire)) begin
            if (gap_left > 0 || pending_bins.size() == 0) begin
                if (gap_left > 0)
                    gap_left--;
                s_axis_tvalid <= 0;
            end else begin
                b = pending_bins.pop_front();
                s_axis_tvalid <= 1;
                s_axis_tdata <= {b.ph, b.mag};
                s_axis_tlast <= b.last;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
        end
    end

    // receiver stall pattern
    logic [9:0] rx_cnt = 0;
    always @(negedge clk)
    begin
        rx_cnt <= rx_cnt + 1;
        case (rx_cnt[9:8])
            2'd0: m_axis_tready <= 1;
            2'd1: m_axis_tready <= $urandom_range(0, 1);
            2'd2: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= rx_cnt[2];
        endcase
    end

    // monitor and watchdog
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        onset_t e;
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                predict_bin('{mag: s_axis_tdata[23:0], ph: s_axis_tdata[39:24],
                              last: s_axis_tlast});
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_onsets.size() == 0) begin
                    $error("unexpected result onset_value=%0d had_history=%0d",
                           m_axis_tdata[33:0], m_axis_tuser[0]);
                    mismatches++;
                end else begin
                    e = expected_onsets.pop_front();
                    if (m_axis_tdata[33:0] !== e.onset) begin
                        $error("onset_value expected %0d actual %0d",
                               e.onset, m_axis_tdata[33:0]);
                        mismatches++;
                    end
                    if (m_axis_tuser[0] !== e.had) begin
                        $error("had_history expected %0d actual %0d",
                               e.had, m_axis_tuser[0]);
                        mismatches++;
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic logic [23:0] rand_mag();
        case ($urandom_range(0, 5))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom) >> $urandom_range(0, 23);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic void push_frame(int len, int kind);
        bin_t b;
        for (int i = 0; i < len; i++) begin
            case (kind)
                1: begin b.mag = 24'hFFFFFF; b.ph = 16'h0000; end
                2: begin
                    b.mag = 24'hFFFFFF;
                    b.ph = ((i / HIST_BINS) % 2 == 0) ? 16'h8000 : 16'h0000;
                end
                default: begin b.mag = rand_mag(); b.ph = 16'($urandom); end
            endcase
            b.last = (i == len - 1);
            pending_bins.push_back(b);
        end
    endfunction

    task automatic drain();
        wait (pending_bins.size() == 0 && !s_axis_tvalid && expected_onsets.size() == 0);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_step(logic [15:0] v);
        @(negedge clk);
        cfg_we <= 1;
        cfg_wdata <= v;
        step_model = v;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    initial
    begin
        logic [15:0] steps[6];
        int          n;
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // first frame wraps past the history depth so every entry is written
        push_frame(HIST_BINS + 3, 0);
        push_frame(1, 0);
        pending_bins.push_back('{mag: 24'hFFFFFF, ph: 16'h7FFF, last: 0});
        pending_bins.push_back('{mag: 24'h000000, ph: 16'h8000, last: 0});
        pending_bins.push_back('{mag: 24'hFFFFFF, ph: 16'h0000, last: 0});
        pending_bins.push_back('{mag: 24'h000001, ph: 16'hFFFF, last: 1});
        push_frame(4, 0);
        drain();

        // saturate the frame sum: opposing full-scale phasors over a long frame
        write_step(16'd0);
        push_frame(HIST_BINS, 1);
        push_frame(2 * HIST_BINS + 90, 2);
        push_frame(3, 0);
        drain();

        steps = '{16'd65535, 16'd16384, 16'd1, 16'd32768, 16'($urandom), 16'd0};
        foreach (steps[p]) begin
            write_step(steps[p]);
            n = 0;
            while (n < 70) begin
                if ($urandom_range(0, 30) == 0)
                    push_frame($urandom_range(HIST_BINS - 20, HIST_BINS + 20), 0);
                else
                    push_frame($urandom_range(1, 12), 0);
                n = n + 12;
            end
            drain();
        end

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
